### src/sba_pkg.sv
package sba_pkg;

	localparam int OFF_W   = 31;
	localparam int BASE_W  = 16;
	localparam int RSIZE_W = 24;
	localparam int CFG_W   = 24;
	localparam int CNT_W   = $clog2(OFF_W);

	localparam logic [OFF_W-1:0] OFF_MASK = {OFF_W{1'b1}};
	localparam logic [7:0]       BYTE_FULL = 8'hFF;

	localparam logic [1:0] OP_FIND = 2'd0;
	localparam logic [1:0] OP_MARK = 2'd1;
	localparam logic [1:0] OP_REL  = 2'd2;

	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_RSIZE = 1'b1;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_RANGE = 2'd2
	} sts_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_DONE
	} state_t;

	function automatic logic [2:0] lowest_zero(input logic [7:0] b);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!b[i]) begin
				pos = 3'(i);
			end
		end
		return pos;
	endfunction

endpackage

### src/sba_map.sv
module sba_map #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/sba_div.sv
module sba_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sba_pkg::OFF_W-1:0]   dividend,
	input  logic [sba_pkg::RSIZE_W-1:0] divisor,
	output logic                        done,
	output logic [sba_pkg::OFF_W-1:0]   quotient
);

	import sba_pkg::*;

	logic [OFF_W-1:0]   dvd_q;
	logic [RSIZE_W-1:0] dsr_q;
	logic [RSIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [RSIZE_W:0]   shifted;
	logic [RSIZE_W:0]   diff;
	logic               take;

	assign shifted = {rem_q, dvd_q[OFF_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign take    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OFF_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[RSIZE_W-1:0] : shifted[RSIZE_W-1:0];
			dvd_q <= {dvd_q[OFF_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### src/slot_bitmap_allocator.sv
// channel   | handshake           | payload
// ----------+---------------------+--------------------------------------
// request   | in_valid / in_ready | op, byte_offset
// result    | out_valid/out_ready | alloc_offset, status
// config    | cfg_we (no wait)    | cfg_index, cfg_data
//
// find: scans the map a byte at a time through the registered read port, then
// multiplies and adds the base; with no free slot it ends after the scan
// mark and release: bit-serial divider (31 steps), then read-modify-write of the
// map byte, skipped when the slot is out of range; below base or unused op: straight to result
// after reset the map is cleared one byte a cycle, in_ready low
// one request in flight; a finished result waits in the output register, and
// the next request is taken while it waits
module slot_bitmap_allocator #(
	parameter int SLOT_COUNT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [sba_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [sba_pkg::OFF_W-1:0]   byte_offset,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sba_pkg::OFF_W-1:0]   alloc_offset,
	output logic [1:0]                  status
);

	import sba_pkg::*;

	localparam int MAP_BYTES = (SLOT_COUNT + 7) / 8;
	localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int SW        = AW + 3;
	localparam int PROD_W    = SW + RSIZE_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);
	localparam logic [31:0]   SLOT_LIM  = 32'(SLOT_COUNT);

	state_t state_q, state_d;

	logic [BASE_W-1:0]  base_q;
	logic [RSIZE_W-1:0] rsize_q;
	logic [RSIZE_W-1:0] eff_rsize;

	logic [1:0]       op_q;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    scan_q;
	logic [AW-1:0]    chk_q;
	logic             chk_vld_q;
	logic [SW-1:0]    slot_q;
	logic [PROD_W-1:0] prod_q;
	logic [OFF_W-1:0] res_off_q;
	sts_t             res_st_q;
	logic             out_valid_q;
	logic [OFF_W-1:0] out_off_q;
	sts_t             out_st_q;

	logic             in_xfer;
	logic             out_load;
	logic             below_base;
	logic [OFF_W-1:0] rel_off;
	logic             div_start;
	logic             div_done;
	logic [OFF_W-1:0] quot;
	logic             quot_range;

	logic             map_we;
	logic [AW-1:0]    map_waddr;
	logic [7:0]       map_wdata;
	logic [AW-1:0]    map_raddr;
	logic [7:0]       map_rdata;

	logic             byte_free;
	logic [SW-1:0]    found_slot;
	logic             found_range;
	logic [SUM_W-1:0] sum;
	logic [63:0]      sum_x;
	logic [7:0]       bit_mask;

	assign eff_rsize  = (rsize_q == '0) ? RSIZE_W'(1) : rsize_q;
	assign in_xfer    = in_valid && in_ready;
	assign below_base = byte_offset < OFF_W'(base_q);
	assign rel_off    = byte_offset - OFF_W'(base_q);
	assign quot_range = 32'(quot) >= SLOT_LIM;
	assign byte_free  = map_rdata != BYTE_FULL;
	assign found_slot = {chk_q, lowest_zero(map_rdata)};
	assign found_range = 32'(found_slot) >= SLOT_LIM;
	assign sum        = SUM_W'(base_q) + SUM_W'(prod_q);
	assign sum_x      = 64'(sum);
	assign bit_mask   = 8'(1) << slot_q[2:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_BYTE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (op == OP_FIND) begin
						state_d = ST_SCAN;
					end else if ((op == OP_MARK || op == OP_REL) && !below_base) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (chk_vld_q && byte_free) begin
					state_d = found_range ? ST_DONE : ST_MUL;
				end else if (chk_vld_q && chk_q == LAST_BYTE) begin
					state_d = ST_DONE;
				end
			end
			ST_MUL:    state_d = ST_ADD;
			ST_ADD:    state_d = ST_DONE;
			ST_DIV: begin
				if (div_done) begin
					state_d = quot_range ? ST_DONE : ST_RMW_RD;
				end
			end
			ST_RMW_RD: state_d = ST_RMW_WR;
			ST_RMW_WR: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		map_we    = 1'b0;
		map_waddr = clr_q;
		map_wdata = 8'h00;
		map_raddr = scan_q;
		case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && (op == OP_MARK || op == OP_REL) && !below_base;
			end
			ST_RMW_RD: begin
				map_raddr = slot_q[SW-1:3];
			end
			ST_RMW_WR: begin
				map_we    = 1'b1;
				map_waddr = slot_q[SW-1:3];
				map_wdata = (op_q == OP_MARK) ? (map_rdata | bit_mask) : (map_rdata & ~bit_mask);
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			base_q      <= '0;
			rsize_q     <= RSIZE_W'(1);
			clr_q       <= '0;
			scan_q      <= '0;
			chk_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_BASE) begin
					base_q <= cfg_data[BASE_W-1:0];
				end else begin
					rsize_q <= cfg_data[RSIZE_W-1:0];
				end
			end
			if (state_q == ST_CLEAR && clr_q != LAST_BYTE) begin
				clr_q <= clr_q + 1'b1;
			end
			if (in_xfer) begin
				scan_q    <= '0;
				chk_vld_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				chk_vld_q <= 1'b1;
				if (scan_q != LAST_BYTE) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			chk_q <= scan_q;
		end
		if (in_xfer) begin
			op_q      <= op;
			res_off_q <= '0;
			res_st_q  <= ((op == OP_MARK || op == OP_REL) && below_base) ? STS_RANGE : STS_OK;
		end
		if (state_q == ST_SCAN && chk_vld_q) begin
			if (byte_free) begin
				slot_q <= found_slot;
				if (found_range) begin
					res_st_q <= STS_FULL;
				end
			end else if (chk_q == LAST_BYTE) begin
				res_st_q <= STS_FULL;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(slot_q) * PROD_W'(eff_rsize);
		end
		if (state_q == ST_ADD) begin
			if (sum_x > 64'(OFF_MASK)) begin
				res_st_q <= STS_RANGE;
			end else begin
				res_off_q <= sum_x[OFF_W-1:0];
			end
		end
		if (state_q == ST_DIV && div_done) begin
			slot_q <= quot[SW-1:0];
			if (quot_range) begin
				res_st_q <= STS_RANGE;
			end
		end
		if (out_load) begin
			out_off_q <= res_off_q;
			out_st_q  <= res_st_q;
		end
	end

	sba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rel_off),
		.divisor  (eff_rsize),
		.done     (div_done),
		.quotient (quot)
	);

	sba_map #(
		.DEPTH (MAP_BYTES),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	assign out_valid    = out_valid_q;
	assign alloc_offset = out_off_q;
	assign status       = out_st_q;

endmodule

### src/sba_chk.sv
module sba_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [sba_pkg::OFF_W-1:0] alloc_offset,
	input logic [1:0]                status
);

	import sba_pkg::*;

	// status code 3 is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STS_OK || status == STS_FULL || status == STS_RANGE))
		else $error("bad status code");

	// a failed request carries no offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |-> alloc_offset == '0)
		else $error("offset on failed request");

	// one request at a time: busy right after a request transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while busy");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(alloc_offset) && $stable(status)))
		else $error("result changed under stall");

endmodule

bind slot_bitmap_allocator sba_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.alloc_offset (alloc_offset),
	.status       (status)
);
